FILE: design/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// Shared types, character codes and classifiers for the key/value line
// tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

    // Default width of the internal line counter
    localparam int KVLT_LINE_NUMBER_WIDTH = 16;
    // Width of the line number as presented on the result port
    localparam int KVLT_LINE_OUT_WIDTH    = 16;

    // Character codes
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Role tag for each echoed byte
    typedef enum logic [2:0] {
        ROLE_SKIP    = 3'd0,
        ROLE_NAME    = 3'd1,
        ROLE_VALUE   = 3'd2,
        ROLE_SEP     = 3'd3,
        ROLE_EOL     = 3'd4,
        ROLE_DISCARD = 3'd5
    } t_role;

    // Sticky error codes
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_ILLEGAL    = 3'd1,
        ERR_NO_NAME    = 3'd2,
        ERR_NO_SEP     = 3'd3,
        ERR_NO_VALUE   = 3'd4,
        ERR_NO_NEWLINE = 3'd5,
        ERR_EOS_MID    = 3'd6
    } t_err;

    // Lexer mode
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_COMMENT = 2'd3
    } t_mode;

    // Position within the line grammar
    typedef enum logic [1:0] {
        POS_NAME  = 2'd0,
        POS_SEP   = 2'd1,
        POS_VALUE = 2'd2,
        POS_EOL   = 2'd3
    } t_pos;

    // One result beat
    typedef struct packed {
        logic [7:0]                     byte_out;
        t_role                          role;
        logic                           token_start;
        logic                           setting_done;
        logic                           value_numeric;
        logic [KVLT_LINE_OUT_WIDTH-1:0] line_number;
        t_err                           error_code;
        logic                           stream_ok;
    } t_result;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

FILE: design/kvlt_in_reg.sv
// ----------------------------------------------------------------------------
// kvlt_in_reg
// Input register stage: captures one byte beat and holds it until the
// parser takes it.
// ----------------------------------------------------------------------------
module kvlt_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_eos
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_eos;

    // Accept a new beat when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_take;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_eos  <= i_eos;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_eos   = r_eos;

endmodule

FILE: design/kvlt_parser.sv
// ----------------------------------------------------------------------------
// kvlt_parser
// Lexer and line-grammar state with the single-pass step logic. Produces
// the result beat for the byte held in the input register.
// ----------------------------------------------------------------------------
module kvlt_parser import kvlt_pkg::*; #(
    parameter int LINE_NUMBER_WIDTH = KVLT_LINE_NUMBER_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_result    o_result
);

    localparam logic [LINE_NUMBER_WIDTH-1:0] LINE_ONE = {{(LINE_NUMBER_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [LINE_NUMBER_WIDTH-1:0] LINE_MAX = {LINE_NUMBER_WIDTH{1'b1}};

    t_mode                        r_mode,  n_mode;
    t_pos                         r_pos,   n_pos;
    logic                         r_kind,  n_kind;
    t_err                         r_err,   n_err;
    logic [LINE_NUMBER_WIDTH-1:0] r_line,  n_line;

    logic                         w_alpha, w_digit, w_alnum, w_newline;
    logic                         w_cont;
    t_err                         w_new_err;
    t_err                         w_eos_err;
    logic [LINE_NUMBER_WIDTH+KVLT_LINE_OUT_WIDTH-1:0] w_line_ext;

    assign w_alpha   = is_alpha(i_byte);
    assign w_digit   = is_digit(i_byte);
    assign w_alnum   = w_alpha || w_digit;
    assign w_newline = (i_byte == CH_NL);

    // Decode: does the byte continue the current token, and does it raise an error
    always_comb begin
        w_cont    = 1'b0;
        w_new_err = ERR_NONE;
        if (r_mode == MODE_COMMENT && !w_newline) begin
            w_cont = 1'b1;
        end else if (r_mode == MODE_WORD && w_alnum) begin
            w_cont = 1'b1;
        end else if (r_mode == MODE_NUMBER && w_digit) begin
            w_cont = 1'b1;
        end
        if (!w_cont) begin
            priority if (is_blank(i_byte) || i_byte == CH_HASH) begin
                w_new_err = ERR_NONE;
            end else if (i_byte == CH_COLON) begin
                unique case (r_pos)
                    POS_NAME:  w_new_err = ERR_NO_NAME;
                    POS_SEP:   w_new_err = ERR_NONE;
                    POS_VALUE: w_new_err = ERR_NO_VALUE;
                    default:   w_new_err = ERR_NO_NEWLINE;
                endcase
            end else if (w_newline) begin
                unique case (r_pos)
                    POS_SEP:   w_new_err = ERR_NO_SEP;
                    POS_VALUE: w_new_err = ERR_NO_VALUE;
                    default:   w_new_err = ERR_NONE;
                endcase
            end else if (w_alnum) begin
                unique case (r_pos)
                    POS_NAME:  w_new_err = w_alpha ? ERR_NONE : ERR_NO_NAME;
                    POS_SEP:   w_new_err = ERR_NO_SEP;
                    POS_VALUE: w_new_err = ERR_NONE;
                    default:   w_new_err = ERR_NO_NEWLINE;
                endcase
            end else begin
                w_new_err = ERR_ILLEGAL;
            end
        end
    end

    // End of stream: an unfinished line becomes an error if none is pending
    assign w_eos_err = (r_err == ERR_NONE && r_pos != POS_NAME) ? ERR_EOS_MID : r_err;

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_pos  = r_pos;
        n_kind = r_kind;
        n_err  = r_err;
        n_line = r_line;
        if (i_eos) begin
            n_mode = MODE_IDLE;
            n_pos  = POS_NAME;
            n_kind = 1'b0;
            n_err  = ERR_NONE;
            n_line = LINE_ONE;
        end else begin
            if (w_newline && r_line != LINE_MAX) begin
                n_line = r_line + LINE_ONE;
            end
            if (r_err == ERR_NONE && !w_cont) begin
                n_mode = MODE_IDLE;
                if (w_new_err != ERR_NONE) begin
                    n_err = w_new_err;
                end else if (i_byte == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (i_byte == CH_COLON) begin
                    n_pos = POS_VALUE;
                end else if (w_newline) begin
                    n_pos = POS_NAME;
                end else if (w_alnum) begin
                    if (r_pos == POS_NAME) begin
                        n_pos  = POS_SEP;
                        n_mode = MODE_WORD;
                    end else begin
                        n_pos  = POS_EOL;
                        n_kind = !w_alpha;
                        n_mode = w_alpha ? MODE_WORD : MODE_NUMBER;
                    end
                end
            end
        end
    end

    // Result beat
    assign w_line_ext = {{KVLT_LINE_OUT_WIDTH{1'b0}}, r_line};

    always_comb begin
        o_result               = '0;
        o_result.line_number   = w_line_ext[KVLT_LINE_OUT_WIDTH-1:0];
        if (i_eos) begin
            o_result.role       = ROLE_SKIP;
            o_result.error_code = w_eos_err;
            o_result.stream_ok  = (w_eos_err == ERR_NONE);
        end else begin
            o_result.byte_out   = i_byte;
            o_result.error_code = r_err;
            priority if (r_err != ERR_NONE) begin
                o_result.role = ROLE_DISCARD;
            end else if (w_new_err != ERR_NONE) begin
                o_result.role       = ROLE_DISCARD;
                o_result.error_code = w_new_err;
            end else if (w_cont) begin
                if (r_mode == MODE_COMMENT) begin
                    o_result.role = ROLE_SKIP;
                end else if (r_mode == MODE_WORD && r_pos == POS_SEP) begin
                    o_result.role = ROLE_NAME;
                end else begin
                    o_result.role = ROLE_VALUE;
                end
            end else if (i_byte == CH_COLON) begin
                o_result.role = ROLE_SEP;
            end else if (w_newline) begin
                o_result.role          = ROLE_EOL;
                o_result.setting_done  = (r_pos == POS_EOL);
                o_result.value_numeric = (r_pos == POS_EOL) && r_kind;
            end else if (w_alnum) begin
                o_result.role        = (r_pos == POS_NAME) ? ROLE_NAME : ROLE_VALUE;
                o_result.token_start = 1'b1;
            end else begin
                o_result.role = ROLE_SKIP;
            end
        end
    end

    // Advance the parser state when a beat moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= POS_NAME;
            r_kind <= 1'b0;
            r_err  <= ERR_NONE;
            r_line <= LINE_ONE;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_kind <= n_kind;
            r_err  <= n_err;
            r_line <= n_line;
        end
    end

endmodule

FILE: design/key_value_line_tokenizer.sv
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Streaming checker for "name : value" settings text, tagging each byte.
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle when the output is not stalled and returns
// one result beat per input beat. A byte passes an input register, one pass
// of lexer and grammar logic, and a result register; the parser state
// advances as the byte enters the result register, so the sustained rate is
// one byte per clock when unstalled. A beat with end-of-stream set reports
// the outcome on stream_ok and returns the parser to its reset state. The
// internal line counter is LINE_NUMBER_WIDTH bits and saturates; its low 16
// bits are shown on the line number output.
module key_value_line_tokenizer import kvlt_pkg::*; #(
    parameter int LINE_NUMBER_WIDTH = KVLT_LINE_NUMBER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic [2:0]  o_role,
    output logic        o_token_start,
    output logic        o_setting_done,
    output logic        o_value_numeric,
    output logic [15:0] o_line_number,
    output logic [2:0]  o_error_code,
    output logic        o_stream_ok
);

    logic       w_held_valid;
    logic [7:0] w_held_byte;
    logic       w_held_eos;
    logic       w_step;
    t_result    w_result;

    logic       r_out_valid;
    t_result    r_out;

    // Move a beat forward when the result register is free or being drained
    assign w_step = w_held_valid && (!r_out_valid || i_out_ready);

    kvlt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_byte_in),
        .i_eos   (i_end_of_stream),
        .i_take  (w_step),
        .o_valid (w_held_valid),
        .o_byte  (w_held_byte),
        .o_eos   (w_held_eos)
    );

    kvlt_parser #(
        .LINE_NUMBER_WIDTH (LINE_NUMBER_WIDTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (w_held_byte),
        .i_eos    (w_held_eos),
        .o_result (w_result)
    );

    // Hold the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= w_held_valid;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_out.byte_out;
    assign o_role          = r_out.role;
    assign o_token_start   = r_out.token_start;
    assign o_setting_done  = r_out.setting_done;
    assign o_value_numeric = r_out.value_numeric;
    assign o_line_number   = r_out.line_number;
    assign o_error_code    = r_out.error_code;
    assign o_stream_ok     = r_out.stream_ok;

endmodule

FILE: design/kvlt_checker.sv
// ----------------------------------------------------------------------------
// kvlt_checker
// Port-level assertions for the key/value line tokenizer, bound to the top.
// ----------------------------------------------------------------------------
module kvlt_checker import kvlt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_byte_out,
    input logic [2:0]  o_role,
    input logic        o_token_start,
    input logic        o_setting_done,
    input logic        o_stream_ok,
    input logic [2:0]  o_error_code
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_byte_out)
            && $stable(o_role) && $stable(o_error_code))
        else $error("result beat changed while stalled");

    // A completed setting is always a line end on a newline byte
    a_done_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_setting_done |-> o_role == ROLE_EOL && o_byte_out == CH_NL
            && o_error_code == ERR_NONE)
        else $error("setting_done on a byte that is not a clean line end");

    // A discarded byte always carries an error code
    a_discard_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_role == ROLE_DISCARD |-> o_error_code != ERR_NONE)
        else $error("discarded byte without an error");

    // Token starts only on name or value bytes
    a_start_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_start |-> o_role == ROLE_NAME || o_role == ROLE_VALUE)
        else $error("token_start on a byte that is not a token");

    // A good stream carries no error
    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_ok |-> o_error_code == ERR_NONE && o_role == ROLE_SKIP)
        else $error("stream_ok with an error pending");

endmodule

bind key_value_line_tokenizer kvlt_checker u_kvlt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_byte_out     (o_byte_out),
    .o_role         (o_role),
    .o_token_start  (o_token_start),
    .o_setting_done (o_setting_done),
    .o_stream_ok    (o_stream_ok),
    .o_error_code   (o_error_code)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key/value line tokenizer.
// ----------------------------------------------------------------------------
// Streams settings text into the block, one byte beat per handshake. The text
// is a short hand-written part that covers three of the error code paths, then
// random settings files, and last a few short settings lines. A behavioural
// parser in this file tags every accepted byte. The monitor compares each result
// beat against it field by field. The sender idles in bursts. The receiver
// stalls on its own pattern, with two long hold-offs that back the block up.
module testbench;
    import kvlt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STUCK_LIMIT     = 5000;
    localparam int RANDOM_BEATS    = 500;
    localparam int TAIL_CYCLES     = 10;

    // Ways in which a generated setting line is broken
    typedef enum int {
        FLAW_NONE,
        FLAW_NO_NAME,
        FLAW_NO_COLON,
        FLAW_NO_VALUE,
        FLAW_EXTRA_TOKEN,
        FLAW_NOISE,
        FLAW_NO_NEWLINE,
        FLAW_DOUBLE_COLON,
        FLAW_DIGIT_NAME
    } t_flaw;

    // Receiver stall behaviour
    typedef enum int {
        SINK_EAGER,
        SINK_LAZY,
        SINK_SLUGGISH
    } t_sink_mode;

    // One queued text beat, or a marker that holds the sender until drained
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       drain;
    } t_text_beat;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_byte_in       = 8'h00;
    logic        i_end_of_stream = 1'b0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_byte_out;
    logic [2:0]  o_role;
    logic        o_token_start;
    logic        o_setting_done;
    logic        o_value_numeric;
    logic [15:0] o_line_number;
    logic [2:0]  o_error_code;
    logic        o_stream_ok;

    t_text_beat  text_queue[$];
    t_result     predicted_tags[$];

    // Parser state of the prediction
    t_mode                            lex_mode;
    t_pos                             gram_pos;
    logic                             val_is_num;
    t_err                             first_err;
    logic [KVLT_LINE_NUMBER_WIDTH-1:0] line_cnt;

    int          mismatches     = 0;
    int          results_seen   = 0;
    bit          beat_taken     = 1'b0;
    int          burst_left     = 0;
    int          gap_left       = 0;
    int          hold_left      = 0;
    int          holdoffs_done  = 0;
    int          mode_left      = 0;
    t_sink_mode  sink_mode      = SINK_EAGER;

    key_value_line_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_byte_in       (i_byte_in),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_byte_out      (o_byte_out),
        .o_role          (o_role),
        .o_token_start   (o_token_start),
        .o_setting_done  (o_setting_done),
        .o_value_numeric (o_value_numeric),
        .o_line_number   (o_line_number),
        .o_error_code    (o_error_code),
        .o_stream_ok     (o_stream_ok)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hold reset, then release it on a falling edge
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
    endfunction

    function automatic logic is_decimal(input logic [7:0] ch);
        return ch >= "0" && ch <= "9";
    endfunction

    function automatic void restart_parser();
        lex_mode   = MODE_IDLE;
        gram_pos   = POS_NAME;
        val_is_num = 1'b0;
        first_err  = ERR_NONE;
        line_cnt   = KVLT_LINE_NUMBER_WIDTH'(1);
    endfunction

    // Tag one text beat and advance the parser
    function automatic t_result tokenize_byte(input logic [7:0] ch, input logic eos);
        t_result r;
        t_err    fault;
        logic    consumed;
        logic    alnum;
        r = '0;
        r.line_number = KVLT_LINE_OUT_WIDTH'(line_cnt);
        alnum = is_letter(ch) || is_decimal(ch);

        // End of stream: report the outcome and start afresh
        if (eos) begin
            if (first_err == ERR_NONE && gram_pos != POS_NAME)
                first_err = ERR_EOS_MID;
            r.error_code = first_err;
            r.stream_ok  = (first_err == ERR_NONE);
            restart_parser();
            return r;
        end

        r.byte_out = ch;
        if (first_err != ERR_NONE) begin
            r.role = ROLE_DISCARD;
        end else begin
            fault    = ERR_NONE;
            consumed = 1'b0;
            // Continue the current token or comment where possible
            if (lex_mode == MODE_COMMENT) begin
                if (ch != CH_NL)
                    consumed = 1'b1;
                else
                    lex_mode = MODE_IDLE;
            end else if (lex_mode == MODE_WORD && alnum) begin
                r.role   = (gram_pos == POS_SEP) ? ROLE_NAME : ROLE_VALUE;
                consumed = 1'b1;
            end else if (lex_mode == MODE_NUMBER && is_decimal(ch)) begin
                r.role   = ROLE_VALUE;
                consumed = 1'b1;
            end

            if (!consumed) begin
                lex_mode = MODE_IDLE;
                if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
                    r.role = ROLE_SKIP;
                end else if (ch == CH_HASH) begin
                    lex_mode = MODE_COMMENT;
                end else if (ch == CH_COLON) begin
                    case (gram_pos)
                        POS_SEP: begin
                            gram_pos = POS_VALUE;
                            r.role   = ROLE_SEP;
                        end
                        POS_NAME:  fault = ERR_NO_NAME;
                        POS_VALUE: fault = ERR_NO_VALUE;
                        default:   fault = ERR_NO_NEWLINE;
                    endcase
                end else if (ch == CH_NL) begin
                    case (gram_pos)
                        POS_NAME: r.role = ROLE_EOL;
                        POS_EOL: begin
                            r.role          = ROLE_EOL;
                            r.setting_done  = 1'b1;
                            r.value_numeric = val_is_num;
                            gram_pos        = POS_NAME;
                        end
                        POS_SEP: fault = ERR_NO_SEP;
                        default: fault = ERR_NO_VALUE;
                    endcase
                end else if (alnum) begin
                    case (gram_pos)
                        POS_NAME: begin
                            if (is_letter(ch)) begin
                                gram_pos      = POS_SEP;
                                r.role        = ROLE_NAME;
                                r.token_start = 1'b1;
                                lex_mode      = MODE_WORD;
                            end else begin
                                fault = ERR_NO_NAME;
                            end
                        end
                        POS_VALUE: begin
                            gram_pos      = POS_EOL;
                            r.role        = ROLE_VALUE;
                            r.token_start = 1'b1;
                            val_is_num    = !is_letter(ch);
                            lex_mode      = is_letter(ch) ? MODE_WORD : MODE_NUMBER;
                        end
                        POS_SEP: fault = ERR_NO_SEP;
                        default: fault = ERR_NO_NEWLINE;
                    endcase
                end else begin
                    fault = ERR_ILLEGAL;
                end
            end

            // The offending byte is discarded and the error sticks
            if (fault != ERR_NONE) begin
                first_err       = fault;
                r.role          = ROLE_DISCARD;
                r.token_start   = 1'b0;
                r.setting_done  = 1'b0;
                r.value_numeric = 1'b0;
            end
        end

        // Every newline advances the line count, saturating
        if (ch == CH_NL && line_cnt != '1)
            line_cnt = line_cnt + 1'b1;
        r.error_code = first_err;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    function automatic void add_byte(input logic [7:0] ch);
        text_queue.push_back('{ch: ch, eos: 1'b0, drain: 1'b0});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // End of stream carries a random byte, which the block must ignore
    function automatic void add_eos();
        text_queue.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1, drain: 1'b0});
    endfunction

    function automatic void add_drain();
        text_queue.push_back('{ch: 8'h00, eos: 1'b0, drain: 1'b1});
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic void add_blanks();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       add_byte(CH_SPACE);
                1:       add_byte(CH_TAB);
                default: add_byte(CH_CR);
            endcase
        end
    endfunction

    // Word: a letter, then letters or digits
    function automatic void add_word();
        int n;
        n = $urandom_range(0, 4);
        add_byte(rand_letter());
        repeat (n)
            add_byte($urandom_range(0, 1) ? rand_letter() : rand_digit());
    endfunction

    function automatic void add_number();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            add_byte(rand_digit());
    endfunction

    // Comment body takes any byte but a newline
    function automatic void add_comment();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        add_byte(CH_HASH);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            add_byte((b == CH_NL) ? CH_HASH : b);
        end
    endfunction

    function automatic void add_noise(input t_flaw flaw, input int spot, input int here);
        if (flaw == FLAW_NOISE && spot == here)
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    // One setting line, intact or broken in the given way
    function automatic void add_setting_line(input t_flaw flaw);
        int spot;
        spot = $urandom_range(0, 3);
        add_blanks();
        add_noise(flaw, spot, 0);
        if (flaw == FLAW_DIGIT_NAME)
            add_byte(rand_digit());
        if (flaw != FLAW_NO_NAME)
            add_word();
        add_blanks();
        add_noise(flaw, spot, 1);
        if (flaw != FLAW_NO_COLON)
            add_byte(CH_COLON);
        if (flaw == FLAW_DOUBLE_COLON)
            add_byte(CH_COLON);
        add_blanks();
        add_noise(flaw, spot, 2);
        if (flaw != FLAW_NO_VALUE) begin
            if ($urandom_range(0, 1))
                add_word();
            else
                add_number();
        end
        if (flaw == FLAW_EXTRA_TOKEN) begin
            add_byte(CH_SPACE);
            add_word();
        end
        add_blanks();
        add_noise(flaw, spot, 3);
        if ($urandom_range(0, 3) == 0)
            add_comment();
        if (flaw != FLAW_NO_NEWLINE)
            add_byte(CH_NL);
    endfunction

    // A random settings file: mostly good lines, some broken, odd endings
    function automatic void add_random_file();
        int lines;
        int pick;
        lines = $urandom_range(1, 8);
        repeat (lines) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                add_blanks();
                if ($urandom_range(0, 1))
                    add_comment();
                add_byte(CH_NL);
            end else if (pick < 85) begin
                add_setting_line(FLAW_NONE);
            end else begin
                add_setting_line(t_flaw'($urandom_range(FLAW_NO_NAME, FLAW_DIGIT_NAME)));
            end
        end
        // Leave the last line open now and then
        case ($urandom_range(0, 9))
            6:       add_setting_line(FLAW_NO_NEWLINE);
            7:       add_word();
            8:       add_comment();
            9:       add_blanks();
            default: ;
        endcase
        add_eos();
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present queued beats at the falling edge, in bursts
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_text
        logic offer;
        offer      = i_in_valid && !beat_taken;
        beat_taken = 1'b0;
        if (i_rst_n && !offer) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
            end else if (text_queue.size() != 0) begin
                if (text_queue[0].drain) begin
                    // Pause until every result is back
                    if (predicted_tags.size() == 0)
                        void'(text_queue.pop_front());
                end else begin
                    i_byte_in       <= text_queue[0].ch;
                    i_end_of_stream <= text_queue[0].eos;
                    void'(text_queue.pop_front());
                    offer = 1'b1;
                    if (burst_left != 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= offer;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern with two long hold-offs
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holdoffs_done < 2 &&
                     results_seen >= ((holdoffs_done == 0) ? 60 : 350)) begin
            hold_left     = HOLD_OFF_CYCLES - 1;
            holdoffs_done = holdoffs_done + 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(SINK_EAGER, SINK_SLUGGISH));
                mode_left = $urandom_range(16, 128);
            end else begin
                mode_left = mode_left - 1;
            end
            case (sink_mode)
                SINK_EAGER: i_out_ready <= 1'b1;
                SINK_LAZY:  i_out_ready <= 1'($urandom_range(0, 1));
                default:    i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result beats, then record accepted text beats
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_ports
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (predicted_tags.size() == 0) begin
                $display("%0t: unexpected result beat, actual byte %0h", $time, o_byte_out);
                mismatches++;
            end else begin
                want = predicted_tags.pop_front();
                check_field("byte_out", 16'(want.byte_out), 16'(o_byte_out));
                check_field("role", 16'(want.role), 16'(o_role));
                check_field("token_start", 16'(want.token_start), 16'(o_token_start));
                check_field("setting_done", 16'(want.setting_done), 16'(o_setting_done));
                check_field("value_numeric", 16'(want.value_numeric),
                            16'(o_value_numeric));
                check_field("line_number", want.line_number, o_line_number);
                check_field("error_code", 16'(want.error_code), 16'(o_error_code));
                check_field("stream_ok", 16'(want.stream_ok), 16'(o_stream_ok));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predicted_tags.push_back(tokenize_byte(i_byte_in, i_end_of_stream));
            beat_taken = 1'b1;
        end
    end

    // Abort when neither channel moves for too long
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("key_value_line_tokenizer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : run_text
        bit paused;
        paused = 1'b0;
        restart_parser();

        // Numeric setting, word setting with skips and a trailing comment
        add_text("a1: 42\n");
        add_text("Zz\t:y9#q\r\n");
        // Comment on an open last line is fine
        add_text("#");
        add_eos();
        // Letter straight after a number raises the missing-newline error
        add_text("k:1x\n");
        add_eos();
        // Illegal bytes at both ends of the range
        add_byte(8'h00);
        add_byte(8'hFF);
        add_eos();
        // Stream ends inside a line
        add_text("k");
        add_eos();
        add_drain();

        while (text_queue.size() < RANDOM_BEATS + 30) begin
            add_random_file();
            if (!paused && text_queue.size() > 280) begin
                add_drain();
                paused = 1'b1;
            end
        end
        add_drain();

        // Close with a short file whose last line stays open
        add_text("a:1\n");
        add_text("b:2\n");
        add_text("c");
        add_eos();

        while (text_queue.size() != 0 || i_in_valid || predicted_tags.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && predicted_tags.size() == 0)
            $display("key_value_line_tokenizer: match");
        else
            $display("key_value_line_tokenizer: mismatch");
        $finish;
    end

endmodule
